// ===== hdl/lru_writeback_chunk_cache_top_macros.svh =====
// ---------------------------------------------------------------------------
// lru_writeback_chunk_cache_top_macros.svh
// Assertion macros used by the chunk cache checker.
// ---------------------------------------------------------------------------
`ifndef LRU_WRITEBACK_CHUNK_CACHE_TOP_MACROS_SVH
`define LRU_WRITEBACK_CHUNK_CACHE_TOP_MACROS_SVH

// Check cons in the same cycle as ante.
`define LWCC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lwcc checker: property failed");

// Check cons in the cycle after ante.
`define LWCC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lwcc checker: property failed");

`endif

// ===== hdl/lwcc_pkg.sv =====
// ---------------------------------------------------------------------------
// lwcc_pkg
// Field widths, opcodes, register indexes and request types of the chunk cache.
// ---------------------------------------------------------------------------
`default_nettype none

package lwcc_pkg;

    localparam int OPCODE_W  = 2;
    localparam int CHUNK_W   = 10;
    localparam int SLOT_FW   = 3;
    localparam int CFG_W     = 11;
    localparam int ACTIVE_W  = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SLOTS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT  = 1'd1;

    localparam logic [ACTIVE_W-1:0] ACTIVE_SLOTS_RESET = 4'd8;
    localparam logic [CFG_W-1:0]    CHUNK_COUNT_RESET  = 11'd1024;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ACQUIRE,
        OP_ACQUIRE_DIRTY,
        OP_FLUSH,
        OP_CLEAR
    } opcode_t;

    typedef struct packed {
        opcode_t              opcode;
        logic [CHUNK_W-1:0]   chunk_index;
    } req_t;

    typedef struct packed {
        logic [SLOT_FW-1:0]   slot;
        logic                 hit;
        logic                 fill_needed;
        logic                 writeback_valid;
        logic [CHUNK_W-1:0]   writeback_chunk;
        logic [SLOT_FW-1:0]   writeback_slot;
        logic                 last;
        logic                 status;
    } rsp_t;

endpackage

`default_nettype wire

// ===== hdl/lru_writeback_chunk_cache_top.sv =====
// ---------------------------------------------------------------------------
// lru_writeback_chunk_cache_top
// Tag and LRU replacement controller of a fully associative write-back cache.
// ---------------------------------------------------------------------------
//   req (req_valid/req_stall) carries one request: acquire, acquire and mark
//   dirty, flush, or clear. rsp (rsp_valid/rsp_stall) returns the responses;
//   rsp.last marks the final response of a request. cfg_we writes
//   active_slots (index 0) or chunk_count (index 1); write only while idle.
//   A hit or fill reads the chunk map, then the slot tag, and answers; an
//   out-of-range request answers after the map read; clear answers with
//   nothing swept. An eviction first scans the ages of the used slots, one
//   slot a cycle. A flush scans the used slots and sends one response per
//   dirty slot, or a single reply if nothing is dirty.
//   req_stall is high until the sequencer is back in idle, so a new request
//   waits until the last one is done. Reset empties the cache at once and
//   restores the register defaults; the chunk map needs no clearing since an
//   entry counts only when its slot is in use and tagged with the chunk.
//   While rsp_stall is high the output register holds its response and the
//   sequencer waits before it loads the next one.
// ---------------------------------------------------------------------------
`default_nettype none

module lru_writeback_chunk_cache_top #(
    parameter int SLOTS      = 8,
    parameter int MAX_CHUNKS = 1024
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_stall,
    input  wire lwcc_pkg::req_t                  req,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_stall,
    output lwcc_pkg::rsp_t                       rsp,
    input  wire logic                            cfg_we,
    input  wire logic [lwcc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lwcc_pkg::CFG_W-1:0]      cfg_data
);

    localparam int CHUNK_W   = lwcc_pkg::CHUNK_W;
    localparam int SLOT_FW   = lwcc_pkg::SLOT_FW;
    localparam int ACTIVE_W  = lwcc_pkg::ACTIVE_W;
    localparam int CFG_W     = lwcc_pkg::CFG_W;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int MAP_DEPTH = (MAX_CHUNKS < (1 << CHUNK_W)) ? MAX_CHUNKS : (1 << CHUNK_W);
    localparam int MAP_AW    = $clog2(MAP_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_CHECK,
        ST_SCAN,
        ST_EVICT,
        ST_FLUSH_SCAN,
        ST_FLUSH_TAG,
        ST_REPLY
    } state_t;

    // Sequencer and configuration state.
    state_t                 state_reg, state_next;
    logic [ACTIVE_W-1:0]    active_slots_reg, active_slots_next;
    logic [CFG_W-1:0]       chunk_count_reg, chunk_count_next;
    lwcc_pkg::opcode_t      op_reg, op_next;
    logic [CHUNK_W-1:0]     idx_reg, idx_next;
    logic                   status_reg, status_next;
    logic [CNT_W-1:0]       used_reg, used_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [SLOT_W-1:0]      best_reg, best_next;
    logic                   emitted_reg, emitted_next;
    logic [SLOTS-1:0]       dirty_reg, dirty_next;
    logic [SLOT_W-1:0]      age_reg [SLOTS];
    logic [SLOT_W-1:0]      age_next [SLOTS];
    logic                   rsp_valid_reg, rsp_valid_next;
    lwcc_pkg::rsp_t         rsp_reg, rsp_next;

    // Memories and their registered read data.
    logic [SLOT_W-1:0]      chunk_map [MAP_DEPTH];
    logic [CHUNK_W-1:0]     slot_tag [SLOTS];
    logic [SLOT_W-1:0]      map_rd_reg;
    logic [CHUNK_W-1:0]     tag_rd_reg;

    logic                   map_we;
    logic [SLOT_W-1:0]      map_wdata;
    logic                   tag_we;
    logic [SLOT_W-1:0]      tag_waddr;
    logic                   tag_re;
    logic [SLOT_W-1:0]      tag_raddr;

    // Age update controls: touch moves one slot to rank 0, fill ages all used slots.
    logic                   age_touch;
    logic                   age_fill;
    logic                   age_clear;
    logic [SLOT_W-1:0]      age_slot;

    logic                   req_accept;
    logic                   rsp_free;
    logic                   in_range;
    logic [CNT_W-1:0]       cap;
    logic                   map_hit;
    logic                   more_dirty;
    logic                   mark_dirty;
    logic [SLOT_W-1:0]      cnt_slot;
    logic [SLOT_W-1:0]      used_slot;

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;
    assign mark_dirty = (op_reg == lwcc_pkg::OP_ACQUIRE_DIRTY);
    assign cnt_slot   = cnt_reg[SLOT_W-1:0];
    assign used_slot  = used_reg[SLOT_W-1:0];
    assign in_range   = (32'(req.chunk_index) < 32'(chunk_count_reg))
                        && (32'(req.chunk_index) < MAX_CHUNKS);
    // Trust a map entry only if its slot is in use and still tagged with this chunk.
    assign map_hit    = (CNT_W'(map_rd_reg) < used_reg) && (tag_rd_reg == idx_reg);

    // Clamp the slot count into 1..SLOTS.
    always_comb
    begin
        if (active_slots_reg == '0)
        begin
            cap = CNT_W'(1);
        end
        else if (32'(active_slots_reg) > SLOTS)
        begin
            cap = CNT_W'(SLOTS);
        end
        else
        begin
            cap = CNT_W'(active_slots_reg);
        end
    end

    // Look for a dirty slot above the current flush position.
    always_comb
    begin
        more_dirty = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if ((CNT_W'(i) > cnt_reg) && (CNT_W'(i) < used_reg) && dirty_reg[i])
            begin
                more_dirty = 1'b1;
            end
        end
    end

    // Update every age rank in parallel.
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            age_next[i] = age_reg[i];
            if (CNT_W'(i) < used_reg)
            begin
                if (age_fill || (age_touch && (age_reg[i] < age_reg[age_slot])))
                begin
                    age_next[i] = age_reg[i] + SLOT_W'(1);
                end
            end
            if ((age_fill || age_touch) && (SLOT_W'(i) == age_slot))
            begin
                age_next[i] = '0;
            end
            if (age_clear)
            begin
                age_next[i] = '0;
            end
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next        = state_reg;
        active_slots_next = active_slots_reg;
        chunk_count_next  = chunk_count_reg;
        op_next           = op_reg;
        idx_next          = idx_reg;
        status_next       = status_reg;
        used_next         = used_reg;
        cnt_next          = cnt_reg;
        best_next         = best_reg;
        emitted_next      = emitted_reg;
        dirty_next        = dirty_reg;
        rsp_valid_next    = rsp_valid_reg && rsp_stall;
        rsp_next          = rsp_reg;
        map_we            = 1'b0;
        map_wdata         = '0;
        tag_we            = 1'b0;
        tag_waddr         = '0;
        tag_re            = 1'b0;
        tag_raddr         = '0;
        age_touch         = 1'b0;
        age_fill          = 1'b0;
        age_clear         = 1'b0;
        age_slot          = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                lwcc_pkg::CFG_ACTIVE_SLOTS: active_slots_next = cfg_data[ACTIVE_W-1:0];
                lwcc_pkg::CFG_CHUNK_COUNT:  chunk_count_next  = cfg_data;
                default:                    chunk_count_next  = chunk_count_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    op_next     = req.opcode;
                    idx_next    = req.chunk_index;
                    status_next = in_range ? lwcc_pkg::STATUS_OK : lwcc_pkg::STATUS_RANGE;
                    case (req.opcode)
                        lwcc_pkg::OP_CLEAR:
                        begin
                            // Drop every entry; stale tags and map entries stay unused.
                            used_next   = '0;
                            dirty_next  = '0;
                            age_clear   = 1'b1;
                            status_next = lwcc_pkg::STATUS_OK;
                            state_next  = ST_REPLY;
                        end
                        lwcc_pkg::OP_FLUSH:
                        begin
                            cnt_next     = '0;
                            emitted_next = 1'b0;
                            state_next   = ST_FLUSH_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_LOOKUP;
                        end
                    endcase
                end
            end

            ST_LOOKUP:
            begin
                if (status_reg == lwcc_pkg::STATUS_RANGE)
                begin
                    state_next = ST_REPLY;
                end
                else
                begin
                    tag_re     = 1'b1;
                    tag_raddr  = map_rd_reg;
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                if (map_hit)
                begin
                    if (rsp_free)
                    begin
                        rsp_valid_next       = 1'b1;
                        rsp_next             = '0;
                        rsp_next.slot        = SLOT_FW'(map_rd_reg);
                        rsp_next.hit         = 1'b1;
                        rsp_next.last        = 1'b1;
                        age_touch            = 1'b1;
                        age_slot             = map_rd_reg;
                        if (mark_dirty)
                        begin
                            dirty_next[map_rd_reg] = 1'b1;
                        end
                        state_next = ST_IDLE;
                    end
                end
                else if (used_reg < cap)
                begin
                    // Fill the next unused slot.
                    if (rsp_free)
                    begin
                        rsp_valid_next          = 1'b1;
                        rsp_next                = '0;
                        rsp_next.slot           = SLOT_FW'(used_slot);
                        rsp_next.fill_needed    = 1'b1;
                        rsp_next.last           = 1'b1;
                        age_fill                = 1'b1;
                        age_slot                = used_slot;
                        tag_we                  = 1'b1;
                        tag_waddr               = used_slot;
                        dirty_next[used_slot]   = mark_dirty;
                        map_we                  = 1'b1;
                        map_wdata               = used_slot;
                        used_next               = used_reg + CNT_W'(1);
                        state_next              = ST_IDLE;
                    end
                end
                else
                begin
                    cnt_next   = CNT_W'(1);
                    best_next  = '0;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Advance one slot a cycle through the age comparator.
                if (cnt_reg >= used_reg)
                begin
                    tag_re     = 1'b1;
                    tag_raddr  = best_reg;
                    state_next = ST_EVICT;
                end
                else
                begin
                    if (age_reg[cnt_slot] > age_reg[best_reg])
                    begin
                        best_next = cnt_slot;
                    end
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            ST_EVICT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next           = 1'b1;
                    rsp_next                 = '0;
                    rsp_next.slot            = SLOT_FW'(best_reg);
                    rsp_next.fill_needed     = 1'b1;
                    rsp_next.last            = 1'b1;
                    if (dirty_reg[best_reg])
                    begin
                        rsp_next.writeback_valid = 1'b1;
                        rsp_next.writeback_chunk = tag_rd_reg;
                        rsp_next.writeback_slot  = SLOT_FW'(best_reg);
                    end
                    age_touch            = 1'b1;
                    age_slot             = best_reg;
                    tag_we               = 1'b1;
                    tag_waddr            = best_reg;
                    dirty_next[best_reg] = mark_dirty;
                    map_we               = 1'b1;
                    map_wdata            = best_reg;
                    state_next           = ST_IDLE;
                end
            end

            ST_FLUSH_SCAN:
            begin
                if (cnt_reg >= used_reg)
                begin
                    if (emitted_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        status_next = lwcc_pkg::STATUS_OK;
                        state_next  = ST_REPLY;
                    end
                end
                else if (dirty_reg[cnt_slot])
                begin
                    tag_re     = 1'b1;
                    tag_raddr  = cnt_slot;
                    state_next = ST_FLUSH_TAG;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            ST_FLUSH_TAG:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next           = 1'b1;
                    rsp_next                 = '0;
                    rsp_next.writeback_valid = 1'b1;
                    rsp_next.writeback_chunk = tag_rd_reg;
                    rsp_next.writeback_slot  = SLOT_FW'(cnt_slot);
                    rsp_next.last            = !more_dirty;
                    dirty_next[cnt_slot]     = 1'b0;
                    cnt_next                 = cnt_reg + CNT_W'(1);
                    emitted_next             = 1'b1;
                    state_next               = ST_FLUSH_SCAN;
                end
            end

            ST_REPLY:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_next        = '0;
                    rsp_next.last   = 1'b1;
                    rsp_next.status = status_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            active_slots_reg <= lwcc_pkg::ACTIVE_SLOTS_RESET;
            chunk_count_reg  <= lwcc_pkg::CHUNK_COUNT_RESET;
            op_reg           <= lwcc_pkg::OP_ACQUIRE;
            idx_reg          <= '0;
            status_reg       <= lwcc_pkg::STATUS_OK;
            used_reg         <= '0;
            cnt_reg          <= '0;
            best_reg         <= '0;
            emitted_reg      <= 1'b0;
            dirty_reg        <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                age_reg[i] <= '0;
            end
            rsp_valid_reg    <= 1'b0;
            rsp_reg          <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            active_slots_reg <= active_slots_next;
            chunk_count_reg  <= chunk_count_next;
            op_reg           <= op_next;
            idx_reg          <= idx_next;
            status_reg       <= status_next;
            used_reg         <= used_next;
            cnt_reg          <= cnt_next;
            best_reg         <= best_next;
            emitted_reg      <= emitted_next;
            dirty_reg        <= dirty_next;
            for (int i = 0; i < SLOTS; i++)
            begin
                age_reg[i] <= age_next[i];
            end
            rsp_valid_reg    <= rsp_valid_next;
            rsp_reg          <= rsp_next;
        end
    end

    // Chunk map: read on accept, write when a chunk takes a slot.
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            chunk_map[idx_reg[MAP_AW-1:0]] <= map_wdata;
        end
        if (req_accept)
        begin
            map_rd_reg <= chunk_map[req.chunk_index[MAP_AW-1:0]];
        end
    end

    // Slot tags: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            slot_tag[tag_waddr] <= idx_reg;
        end
        if (tag_re)
        begin
            tag_rd_reg <= slot_tag[tag_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lwcc_checker.sv =====
// ---------------------------------------------------------------------------
// lwcc_checker
// Port-level checks of the chunk cache, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "lru_writeback_chunk_cache_top_macros.svh"

module lwcc_checker (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    input  wire logic            req_stall,
    input  wire logic            rsp_valid,
    input  wire logic            rsp_stall,
    input  wire lwcc_pkg::rsp_t  rsp
);

    // One request at a time: hold off the next one after an accept.
    `LWCC_ASSERT_NXT(a_busy_after_accept, clk, rst_n, req_valid && !req_stall, req_stall)

    // A stalled response holds.
    `LWCC_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

    // An out-of-range response carries nothing else.
    `LWCC_ASSERT_IMP(a_range_alone, clk, rst_n, rsp_valid && rsp.status, rsp.last && !rsp.hit && !rsp.fill_needed && !rsp.writeback_valid)

    // A hit neither fills nor writes back.
    `LWCC_ASSERT_IMP(a_hit_clean, clk, rst_n, rsp_valid && rsp.hit, rsp.last && !rsp.fill_needed && !rsp.writeback_valid)

    // Only flush write-backs come ahead of the final response.
    `LWCC_ASSERT_IMP(a_multi_flush, clk, rst_n, rsp_valid && !rsp.last, rsp.writeback_valid && !rsp.fill_needed && !rsp.hit)

endmodule

bind lru_writeback_chunk_cache_top lwcc_checker u_lwcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire
